[src/srs_pkg.sv]
package srs_pkg;

	// Widths fixed by the item fields
	localparam int SEQ_W = 16;
	localparam int PAY_W = 64;
	localparam int WS_W  = 5;

	// Window geometry
	localparam int WIN_MAX = 16;
	localparam int IDX_W   = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
	localparam int CNT_W   = $clog2(WIN_MAX + 1);

	// Register reset values
	localparam logic [WS_W-1:0]  WS_RESET    = 5'd4;
	localparam logic [SEQ_W-1:0] START_RESET = 16'd0;

	// Register indexes on the configuration port
	localparam logic REG_WINDOW_SIZE = 1'b0;
	localparam logic REG_START_SEQ   = 1'b1;

	// Operation codes
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	typedef enum logic [2:0] {
		KIND_SENT        = 3'd0,
		KIND_REFUSED     = 3'd1,
		KIND_ACK_OK      = 3'd2,
		KIND_ACK_IGNORED = 3'd3,
		KIND_RETRANSMIT  = 3'd4,
		KIND_TMO_IGNORED = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SLIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [PAY_W-1:0] message_word;
		logic [SEQ_W-1:0] ack_seq;
		logic             ack_checksum_ok;
		logic [SEQ_W-1:0] timeout_seq;
	} req_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] packet_word;
		logic             start_timer;
		logic             stop_timer;
		logic [SEQ_W-1:0] window_base;
		logic             waiting;
	} rsp_item_t;

	// Broadcast control for the slot cells
	typedef struct packed {
		logic             clear;
		logic             shift;
		logic             write;
		logic             mark;
		logic [IDX_W-1:0] sel;
	} cell_ctrl_t;

	// Register values and restart request from the configuration port
	typedef struct packed {
		logic [WS_W-1:0]  window_size;
		logic             restart;
		logic [SEQ_W-1:0] restart_seq;
	} cfg_t;

endpackage

[src/selective_repeat_sender.sv]
// Selective-repeat ARQ sender.
// Request channel (req_valid/req_ready/req) carries one operation per
// transaction: send a message, report an arrived ack, or report an expired
// timer. Every operation but the unused code gives one response transaction
// (rsp_valid/rsp_ready/rsp) with the outcome, the window base and the
// waiting flag after the step; the unused code is dropped without response.
// An ack slides the base over the acked slots at its head, one slot per
// cycle through the row of slot cells. One transaction is handled at a
// time: the next request is taken once the current result sits in the
// output register.
// A stalled receiver holds the output register; a later result then waits
// in the sequencer until the output register is free.
// Reset clears the window (base = next = 0), the waiting flag and all ack
// marks and sets window_size to 4. Writing start_seq over the APB port does
// the same restart at the written number.
module selective_repeat_sender import srs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_item_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t             cfg;
	state_t           state_q, state_d;
	req_item_t        req_q;
	logic [SEQ_W-1:0] base_q, next_q;
	logic [CNT_W-1:0] count_q;
	logic             waiting_q;
	rsp_item_t        res_q, res_d;
	rsp_item_t        rsp_q;
	logic             rsp_valid_q;

	cell_ctrl_t       ctrl;
	logic [PAY_W-1:0] cell_word [WIN_MAX];
	logic [WIN_MAX-1:0] cell_acked;

	logic [CNT_W-1:0] eff_window;
	logic [SEQ_W-1:0] probe_seq;
	logic [SEQ_W-1:0] offset;
	logic             in_window;
	logic             refuse;
	logic             do_send;
	logic             slide_go;
	logic             load_rsp;

	srs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Row of slot cells; cell 0 holds the base slot
	for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
		logic [PAY_W-1:0] nxt_word;
		logic             nxt_acked;
		if (i < WIN_MAX - 1) begin : g_mid
			assign nxt_word  = cell_word[i+1];
			assign nxt_acked = cell_acked[i+1];
		end else begin : g_end
			assign nxt_word  = cell_word[0];
			assign nxt_acked = 1'b0;
		end
		srs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.idx       (IDX_W'(i)),
			.wr_word   (req_q.message_word),
			.nxt_word  (nxt_word),
			.nxt_acked (nxt_acked),
			.word      (cell_word[i]),
			.acked     (cell_acked[i])
		);
	end

	// Effective window: zero counts as one, clamp at the row length
	always_comb begin
		if (cfg.window_size == '0) begin
			eff_window = CNT_W'(1);
		end else if (32'(cfg.window_size) > WIN_MAX) begin
			eff_window = CNT_W'(WIN_MAX);
		end else begin
			eff_window = CNT_W'(cfg.window_size);
		end
	end

	// Window position of the ack or timeout number
	assign probe_seq = (req_q.operation == OP_ACK) ? req_q.ack_seq : req_q.timeout_seq;
	assign offset    = probe_seq - base_q;
	assign in_window = (offset < SEQ_W'(count_q));
	assign refuse    = waiting_q || (count_q >= eff_window);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (req_q.operation)
					OP_NONE: state_d = ST_IDLE;
					OP_ACK:  state_d = ST_SLIDE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_SLIDE: begin
				if (!slide_go) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_rsp) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and cell control
	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		slide_go   = (state_q == ST_SLIDE) && (count_q != '0) && cell_acked[0];
		load_rsp   = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
		do_send    = (state_q == ST_EXEC) && (req_q.operation == OP_SEND) && !refuse;
		ctrl.clear = cfg.restart;
		ctrl.shift = slide_go;
		ctrl.write = do_send;
		ctrl.mark  = (state_q == ST_EXEC) && (req_q.operation == OP_ACK) &&
		             req_q.ack_checksum_ok && in_window;
		ctrl.sel   = (req_q.operation == OP_SEND) ? count_q[IDX_W-1:0] : offset[IDX_W-1:0];
	end

	// Outcome of the operation in hand
	always_comb begin
		res_d             = res_q;
		res_d.packet_word = '0;
		res_d.start_timer = 1'b0;
		res_d.stop_timer  = 1'b0;
		case (req_q.operation)
			OP_SEND: begin
				res_d.seq = next_q;
				if (refuse) begin
					res_d.kind = KIND_REFUSED;
				end else begin
					res_d.kind        = KIND_SENT;
					res_d.packet_word = req_q.message_word;
					res_d.start_timer = 1'b1;
				end
			end
			OP_ACK: begin
				res_d.seq = req_q.ack_seq;
				if (req_q.ack_checksum_ok && in_window) begin
					res_d.kind       = KIND_ACK_OK;
					res_d.stop_timer = 1'b1;
				end else begin
					res_d.kind = KIND_ACK_IGNORED;
				end
			end
			default: begin
				res_d.seq = req_q.timeout_seq;
				if (in_window) begin
					res_d.kind        = KIND_RETRANSMIT;
					res_d.packet_word = cell_word[offset[IDX_W-1:0]];
					res_d.start_timer = 1'b1;
				end else begin
					res_d.kind = KIND_TMO_IGNORED;
				end
			end
		endcase
	end

	// Sequencer state and window counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= START_RESET;
			next_q    <= START_RESET;
			count_q   <= '0;
			waiting_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.restart) begin
				base_q    <= cfg.restart_seq;
				next_q    <= cfg.restart_seq;
				count_q   <= '0;
				waiting_q <= 1'b0;
			end else if (state_q == ST_EXEC) begin
				case (req_q.operation)
					OP_SEND: begin
						if (do_send) begin
							next_q  <= next_q + SEQ_W'(1);
							count_q <= count_q + CNT_W'(1);
						end else begin
							waiting_q <= 1'b1;
						end
					end
					OP_ACK:  waiting_q <= 1'b0;
					default: ;
				endcase
			end else if (slide_go) begin
				base_q  <= base_q + SEQ_W'(1);
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Hold the request and the pending result
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == ST_EXEC) begin
			res_q <= res_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q             <= res_q;
			rsp_q.window_base <= base_q;
			rsp_q.waiting     <= waiting_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Slots beyond the packets in flight carry no ack mark
	logic [WIN_MAX-1:0] beyond_mask;
	always_comb begin
		for (int i = 0; i < WIN_MAX; i++) begin
			beyond_mask[i] = (CNT_W'(i) >= count_q);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= WIN_MAX)
		else $error("packets in flight exceed the window");

	a_count_span: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q - base_q) == SEQ_W'(count_q))
		else $error("next and base disagree with the in-flight count");

	a_no_stray_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_acked & beyond_mask) == '0)
		else $error("ack mark outside the window");

	a_slide_only_acked: assert property (@(posedge clk) disable iff (!arst_n)
		slide_go |=> (base_q == $past(base_q) + SEQ_W'(1)) || $past(cfg.restart))
		else $error("base did not advance on a slide");
`endif

endmodule

[src/srs_cell.sv]
module srs_cell import srs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] idx,
	input  logic [PAY_W-1:0] wr_word,
	input  logic [PAY_W-1:0] nxt_word,
	input  logic             nxt_acked,
	output logic [PAY_W-1:0] word,
	output logic             acked
);

	logic [PAY_W-1:0] word_q;
	logic             acked_q;
	logic             hit;

	assign hit = (ctrl.sel == idx);

	// Payload: take the neighbour's on a slide, the new message on a write
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			word_q <= nxt_word;
		end else if (ctrl.write && hit) begin
			word_q <= wr_word;
		end
	end

	// Ack mark: clear on restart, follow the neighbour on a slide, clear on a write, set on a mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q <= 1'b0;
		end else if (ctrl.clear) begin
			acked_q <= 1'b0;
		end else if (ctrl.shift) begin
			acked_q <= nxt_acked;
		end else if (ctrl.write && hit) begin
			acked_q <= 1'b0;
		end else if (ctrl.mark && hit) begin
			acked_q <= 1'b1;
		end
	end

	assign word  = word_q;
	assign acked = acked_q;

endmodule

[src/srs_cfg.sv]
module srs_cfg import srs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic             wr;
	logic             reg_sel;
	logic [WS_W-1:0]  window_size_q;
	logic [SEQ_W-1:0] start_seq_q;

	assign wr      = psel && penable && pwrite;
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WS_RESET;
			start_seq_q   <= START_RESET;
		end else if (wr) begin
			case (reg_sel)
				REG_WINDOW_SIZE: window_size_q <= pwdata[WS_W-1:0];
				REG_START_SEQ:   start_seq_q   <= pwdata[SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_sel)
			REG_WINDOW_SIZE: prdata = 32'(window_size_q);
			REG_START_SEQ:   prdata = 32'(start_seq_q);
			default:         prdata = '0;
		endcase
	end

	// A start_seq write restarts the sender in the same cycle
	assign cfg.window_size = window_size_q;
	assign cfg.restart     = wr && (reg_sel == REG_START_SEQ);
	assign cfg.restart_seq = pwdata[SEQ_W-1:0];

endmodule

[sim/selective_repeat_sender_tb.sv]
`timescale 1ns / 100ps

module selective_repeat_sender_tb;
	import srs_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 193;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_item_t   req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_item_t   rsp;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	// Sender state as predicted
	logic [WS_W-1:0]  cfg_window;
	logic [SEQ_W-1:0] cfg_start;
	logic [SEQ_W-1:0] win_base;
	logic [SEQ_W-1:0] win_next;
	logic             win_waiting;
	logic [PAY_W-1:0] slot_word [WIN_MAX];
	logic             slot_ack  [WIN_MAX];
	int unsigned      base_slot;

	req_item_t   pending_reqs[$];
	rsp_item_t   expected_rsps[$];
	int unsigned req_gap      = 0;
	int unsigned rsp_stall    = 0;
	logic        req_gap_on   = 1'b1;
	logic        rsp_stall_on = 1'b1;
	int unsigned fail_count   = 0;

	selective_repeat_sender u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	// Clear the window and restart numbering at the configured start
	function automatic void restart_window();
		win_base    = cfg_start;
		win_next    = cfg_start;
		win_waiting = 1'b0;
		base_slot   = 0;
		for (int i = 0; i < WIN_MAX; i++) begin
			slot_word[i] = '0;
			slot_ack[i]  = 1'b0;
		end
	endfunction

	// Zero counts as one, anything above the maximum is clamped
	function automatic int unsigned win_limit();
		if (cfg_window == 0)
			return 1;
		if (cfg_window > WIN_MAX)
			return WIN_MAX;
		return cfg_window;
	endfunction

	// Advance the predicted sender by one accepted transaction
	function automatic void sender_step(input req_item_t it);
		rsp_item_t        r;
		logic [SEQ_W-1:0] in_flight;
		logic [SEQ_W-1:0] offset;
		int unsigned      slot;

		if (it.operation == OP_NONE)
			return;
		r = '0;
		in_flight = win_next - win_base;
		case (it.operation)
			OP_SEND: begin
				r.seq  = win_next;
				r.kind = KIND_REFUSED;
				if (!win_waiting && in_flight >= win_limit()) begin
					win_waiting = 1'b1;
				end else if (!win_waiting) begin
					slot = (base_slot + in_flight) % WIN_MAX;
					slot_word[slot] = it.message_word;
					slot_ack[slot]  = 1'b0;
					r.kind          = KIND_SENT;
					r.packet_word   = it.message_word;
					r.start_timer   = 1'b1;
					win_next        = win_next + 1'b1;
				end
			end
			OP_ACK: begin
				offset = it.ack_seq - win_base;
				r.seq  = it.ack_seq;
				r.kind = KIND_ACK_IGNORED;
				if (it.ack_checksum_ok && offset < in_flight) begin
					slot_ack[(base_slot + offset) % WIN_MAX] = 1'b1;
					r.kind       = KIND_ACK_OK;
					r.stop_timer = 1'b1;
				end
				// Slide the base over every acked slot at its head
				while (win_base != win_next && slot_ack[base_slot]) begin
					slot_ack[base_slot] = 1'b0;
					base_slot = (base_slot + 1) % WIN_MAX;
					win_base  = win_base + 1'b1;
				end
				win_waiting = 1'b0;
			end
			default: begin
				offset = it.timeout_seq - win_base;
				r.seq  = it.timeout_seq;
				r.kind = KIND_TMO_IGNORED;
				if (offset < in_flight) begin
					r.kind        = KIND_RETRANSMIT;
					r.packet_word = slot_word[(base_slot + offset) % WIN_MAX];
					r.start_timer = 1'b1;
				end
			end
		endcase
		r.window_base = win_base;
		r.waiting     = win_waiting;
		expected_rsps.push_back(r);
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				sender_step(req);
			end
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap = req_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					req_gap = req_gap_on ? idle_len() : 0;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response transaction with nothing expected: kind %0d seq 0x%0h",
						rsp.kind, rsp.seq);
					fail_count++;
				end else begin
					rsp_item_t want;
					want = expected_rsps.pop_front();
					check_field("kind", 64'(want.kind), 64'(rsp.kind));
					check_field("seq", 64'(want.seq), 64'(rsp.seq));
					check_field("packet_word", want.packet_word, rsp.packet_word);
					check_field("start_timer", 64'(want.start_timer), 64'(rsp.start_timer));
					check_field("stop_timer", 64'(want.stop_timer), 64'(rsp.stop_timer));
					check_field("window_base", 64'(want.window_base), 64'(rsp.window_base));
					check_field("waiting", 64'(want.waiting), 64'(rsp.waiting));
				end
			end
			if (rsp_stall > 0) begin
				rsp_stall = rsp_stall - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (rsp_stall_on && $urandom_range(0, 3) == 0)
					rsp_stall = idle_len();
			end
		end
	end

	// Queue one transaction, holding off while the driver is well fed
	task automatic push_req(input logic [1:0] op, input logic [PAY_W-1:0] msg,
			input logic [SEQ_W-1:0] ack, input logic ok, input logic [SEQ_W-1:0] tmo);
		req_item_t it;
		it.operation       = op;
		it.message_word    = msg;
		it.ack_seq         = ack;
		it.ack_checksum_ok = ok;
		it.timeout_seq     = tmo;
		while (pending_reqs.size() >= 2)
			@(posedge clk);
		pending_reqs.push_back(it);
	endtask

	// Hold until every transaction is answered, then let the block settle
	task automatic wait_idle();
		int unsigned n;
		n = 0;
		while ((pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
				&& n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (n >= DRAIN_LIMIT) begin
			$error("responses still outstanding: %0d", expected_rsps.size());
			fail_count++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic reg_index, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_index == REG_WINDOW_SIZE) begin
			cfg_window = data[WS_W-1:0];
		end else begin
			cfg_start = data[SEQ_W-1:0];
			restart_window();
		end
	endtask

	// Random transaction, aimed mostly at or just past the current window
	task automatic push_random(output logic counted);
		int unsigned      r;
		logic [1:0]       op;
		logic [SEQ_W-1:0] ack;
		logic [SEQ_W-1:0] tmo;
		r = $urandom_range(0, 99);
		if (r < 5)
			op = OP_NONE;
		else if (r < 50)
			op = OP_SEND;
		else if (r < 85)
			op = OP_ACK;
		else
			op = OP_TIMEOUT;
		ack = ($urandom_range(0, 99) < 80) ?
			win_base + SEQ_W'($urandom_range(0, win_limit())) : SEQ_W'($urandom);
		tmo = ($urandom_range(0, 99) < 75) ?
			win_base + SEQ_W'($urandom_range(0, win_limit())) : SEQ_W'($urandom);
		push_req(op, {$urandom, $urandom}, ack, $urandom_range(0, 99) < 85, tmo);
		counted = (op != OP_NONE);
	endtask

	initial begin
		logic [WS_W-1:0] ws;
		int unsigned     sent;
		logic            counted;

		cfg_window = WS_RESET;
		cfg_start  = START_RESET;
		restart_window();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty window, fill and overfill, acks and timeouts
		push_req(OP_TIMEOUT, '0, '0, 1'b1, 16'h0000);
		push_req(OP_ACK, '0, 16'h0000, 1'b1, '0);
		push_req(OP_SEND, '1, '0, 1'b0, '0);
		push_req(OP_SEND, '0, '1, 1'b1, '1);
		push_req(OP_SEND, 64'hA5A5_A5A5_A5A5_A5A5, '0, 1'b0, '0);
		push_req(OP_SEND, 64'h5A5A_5A5A_5A5A_5A5A, '0, 1'b0, '0);
		push_req(OP_SEND, 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0);
		push_req(OP_SEND, 64'hFEDC_BA98_7654_3210, '0, 1'b0, '0);
		push_req(OP_TIMEOUT, '0, '0, 1'b0, 16'h0001);
		push_req(OP_ACK, '0, 16'h0001, 1'b0, '0);
		push_req(OP_ACK, '0, 16'h0001, 1'b1, '0);
		push_req(OP_ACK, '0, 16'h0001, 1'b1, '0);
		push_req(OP_ACK, '0, 16'h0000, 1'b1, '0);
		push_req(OP_ACK, '0, 16'hFFFF, 1'b1, '0);
		push_req(OP_TIMEOUT, '0, '0, 1'b1, 16'hFFFF);
		push_req(OP_NONE, '1, '1, 1'b1, '1);
		push_req(OP_TIMEOUT, '0, '0, 1'b0, 16'h0002);
		push_req(OP_TIMEOUT, '0, '0, 1'b0, 16'h0004);
		push_req(OP_ACK, '0, 16'h0004, 1'b1, '0);
		push_req(OP_ACK, '0, 16'h0002, 1'b1, '0);
		push_req(OP_ACK, '0, 16'h0003, 1'b1, '0);
		wait_idle();

		// Random phases across window sizes and start numbers
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ws = 5'd1;
				1: ws = 5'd16;
				2: ws = 5'd2;
				3: ws = 5'd0;
				4: ws = 5'd31;
				default: ws = WS_W'($urandom_range(1, WIN_MAX));
			endcase
			reg_write(REG_WINDOW_SIZE, 32'(ws));
			case (p)
				0: reg_write(REG_START_SEQ, 32'hFFFE);
				3: reg_write(REG_START_SEQ, 32'h0000);
				4: reg_write(REG_START_SEQ, 32'hFFF8);
				5: reg_write(REG_START_SEQ, 32'hFFFF);
				1, 2: ;
				default: if ($urandom_range(0, 1) == 1)
					reg_write(REG_START_SEQ, 32'($urandom_range(0, 65535)));
			endcase
			req_gap_on   = (p % 3 != 0);
			rsp_stall_on = (p % 4 != 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				push_random(counted);
				if (counted)
					sent++;
			end
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

[files.f]
src/srs_pkg.sv
src/srs_cell.sv
src/srs_cfg.sv
src/selective_repeat_sender.sv
sim/selective_repeat_sender_tb.sv
